// ===== hdl/mi3_pkg.sv =====
// Shared types and a fixed-point saturation helper for the 3x3 matrix inverse core.
package mi3_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned NUM_ELEM = 9;
	localparam int unsigned TOL_W = 31;
	localparam logic [TOL_W-1:0] TOL_RESET = 31'd1;

	typedef logic signed [DATA_W-1:0] fx_t;
	typedef fx_t mat_t [NUM_ELEM];

	// Saturate a signed 34-bit sum or difference to 32 bits.
	function automatic fx_t sat34(input logic signed [33:0] v);
		fx_t r;
		if (v > 34'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -34'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/matrix_inverse_3x3_core.sv =====
// 3x3 matrix inverse by adjugate, signed fixed point, fully pipelined.
// Throughput: one matrix per cycle; the whole pipeline advances when the
// output register is free or being drained (valid/ready, no bubbles).
// Pipeline sections in order: cofactor lanes, determinant, magnitude, reciprocal,
// scaling, output register.
// Reset: arst_n clears valid flags and sets the singular tolerance (tol_q) to 1.
module matrix_inverse_3x3_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [31:0] elem_r0c0, elem_r0c1, elem_r0c2,
	input  logic signed [31:0] elem_r1c0, elem_r1c1, elem_r1c2,
	input  logic signed [31:0] elem_r2c0, elem_r2c1, elem_r2c2,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] inv_r0c0, inv_r0c1, inv_r0c2,
	output logic signed [31:0] inv_r1c0, inv_r1c1, inv_r1c2,
	output logic signed [31:0] inv_r2c0, inv_r2c1, inv_r2c2,
	output logic        singular
);
	localparam int RCP_LAT = 2 * FRAC_BITS + 2;
	localparam int PIPE_LAT = 3 + 4 + RCP_LAT + 3;
	localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

	logic [mi3_pkg::TOL_W-1:0] tol_q;
	logic en;
	logic [PIPE_LAT-1:0] vld_q;
	mi3_pkg::mat_t m;
	mi3_pkg::fx_t c [11];

	assign cfg_ready = 1'b1;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= mi3_pkg::TOL_RESET;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	assign m[0] = elem_r0c0; assign m[1] = elem_r0c1; assign m[2] = elem_r0c2;
	assign m[3] = elem_r1c0; assign m[4] = elem_r1c1; assign m[5] = elem_r1c2;
	assign m[6] = elem_r2c0; assign m[7] = elem_r2c1; assign m[8] = elem_r2c2;

	// operand indices per lane: nine adjugate cofactors plus two minors
	localparam int IA [11] = '{4, 2, 1, 5, 0, 2, 3, 1, 0, 3, 3};
	localparam int IB [11] = '{8, 7, 5, 6, 8, 3, 7, 6, 4, 8, 7};
	localparam int IC [11] = '{5, 1, 2, 3, 2, 0, 4, 0, 1, 5, 4};
	localparam int ID [11] = '{7, 8, 4, 8, 6, 5, 6, 7, 3, 6, 6};

	for (genvar l = 0; l < 11; l++) begin : g_lane
		mi3_cof_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk(clk), .en(en),
			.a(m[IA[l]]), .b(m[IB[l]]), .c(m[IC[l]]), .d(m[ID[l]]),
			.cof(c[l])
		);
	end

	// delay row 0 alongside the lanes
	mi3_pkg::fx_t r0_s1 [3], r0_s2 [3], r0_s3 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			r0_s1 <= '{m[0], m[1], m[2]};
			r0_s2 <= r0_s1;
			r0_s3 <= r0_s2;
		end
	end

	// determinant: three products, difference, sum
	mi3_pkg::fx_t t0, t1, t2, t2_s4, d01_s4, det_s5;
	mi3_mul #(.FRAC_BITS(FRAC_BITS)) u_t0 (.clk(clk), .en(en), .a(r0_s3[0]), .b(c[0]), .p(t0));
	mi3_mul #(.FRAC_BITS(FRAC_BITS)) u_t1 (.clk(clk), .en(en), .a(r0_s3[1]), .b(c[9]), .p(t1));
	mi3_mul #(.FRAC_BITS(FRAC_BITS)) u_t2 (.clk(clk), .en(en), .a(r0_s3[2]), .b(c[10]), .p(t2));
	always_ff @(posedge clk) begin
		if (en) begin
			d01_s4 <= mi3_pkg::sat34(34'(t0) - 34'(t1));
			t2_s4 <= t2;
			det_s5 <= mi3_pkg::sat34(34'(d01_s4) + 34'(t2_s4));
		end
	end

	// magnitude and singular test
	logic [31:0] mag_s6;
	logic neg_s6, sing_s6;
	logic [31:0] mag;
	assign mag = det_s5[31] ? 32'(-det_s5) : 32'(det_s5);
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s6 <= mag;
			neg_s6 <= det_s5[31];
			sing_s6 <= (mag <= {1'b0, tol_q}) || (mag == '0);
		end
	end

	// cofactors and flag wait out the determinant, magnitude and reciprocal
	localparam int CDLY = 5 + RCP_LAT;
	mi3_pkg::fx_t cd_q [CDLY][9];
	logic sd_q [RCP_LAT];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) cd_q[0][k] <= c[k];
			for (int s = 1; s < CDLY; s++) cd_q[s] <= cd_q[s-1];
			sd_q[0] <= sing_s6;
			for (int s = 1; s < RCP_LAT; s++) sd_q[s] <= sd_q[s-1];
		end
	end

	mi3_pkg::fx_t recip;
	mi3_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
		.clk(clk), .en(en), .mag(mag_s6), .neg(neg_s6), .recip(recip)
	);

	// scaling lanes
	mi3_pkg::fx_t sc [9];
	for (genvar k = 0; k < 9; k++) begin : g_scale
		mi3_mul #(.FRAC_BITS(FRAC_BITS)) u_sc (
			.clk(clk), .en(en), .a(recip), .b(cd_q[CDLY-1][k]), .p(sc[k])
		);
	end
	logic sg_s1, sg_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			sg_s1 <= sd_q[RCP_LAT-1];
			sg_s2 <= sg_s1;
		end
	end

	// valid pipeline and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], in_valid};
			out_valid <= vld_q[PIPE_LAT-1];
		end
	end

	// merge: identity when singular
	mi3_pkg::fx_t res [9];
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			if (sg_s2) begin
				res[k] = (k % 4 == 0) ? ONE : '0;
			end else begin
				res[k] = sc[k];
			end
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			inv_r0c0 <= res[0]; inv_r0c1 <= res[1]; inv_r0c2 <= res[2];
			inv_r1c0 <= res[3]; inv_r1c1 <= res[4]; inv_r1c2 <= res[5];
			inv_r2c0 <= res[6]; inv_r2c1 <= res[7]; inv_r2c2 <= res[8];
			singular <= sg_s2;
		end
	end
endmodule

// ===== hdl/mi3_mul.sv =====
// Registered Q-format multiply: round to nearest (ties up), saturate to 32 bits.
module mi3_mul #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        en,
	input  mi3_pkg::fx_t a,
	input  mi3_pkg::fx_t b,
	output mi3_pkg::fx_t p
);
	logic signed [63:0] prod_s1;
	logic signed [64:0] rnd;
	logic signed [64:0] shf;
	mi3_pkg::fx_t       res;

	// stage 1: raw product
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= a * b;
		end
	end

	// round, arithmetic shift, saturate
	always_comb begin
		rnd = {prod_s1[63], prod_s1} + (65'sd1 <<< (FRAC_BITS - 1));
		shf = rnd >>> FRAC_BITS;
		if (shf > 65'sh0_7FFF_FFFF) begin
			res = 32'sh7FFF_FFFF;
		end else if (shf < -65'sh0_8000_0000) begin
			res = 32'sh8000_0000;
		end else begin
			res = shf[31:0];
		end
	end

	// stage 2: rounded result
	always_ff @(posedge clk) begin
		if (en) begin
			p <= res;
		end
	end
endmodule

// ===== hdl/mi3_cof_lane.sv =====
// One cofactor lane: two products and a saturated difference, three stages.
module mi3_cof_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         en,
	input  mi3_pkg::fx_t a,
	input  mi3_pkg::fx_t b,
	input  mi3_pkg::fx_t c,
	input  mi3_pkg::fx_t d,
	output mi3_pkg::fx_t cof
);
	mi3_pkg::fx_t pab, pcd;

	mi3_mul #(.FRAC_BITS(FRAC_BITS)) u_ab (.clk(clk), .en(en), .a(a), .b(b), .p(pab));
	mi3_mul #(.FRAC_BITS(FRAC_BITS)) u_cd (.clk(clk), .en(en), .a(c), .b(d), .p(pcd));

	// difference stage
	always_ff @(posedge clk) begin
		if (en) begin
			cof <= mi3_pkg::sat34(34'(pab) - 34'(pcd));
		end
	end
endmodule

// ===== hdl/mi3_recip.sv =====
// Pipelined reciprocal 2^(2F)/|det|: one quotient bit per stage, then signed saturate.
module mi3_recip #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         en,
	input  logic [31:0]  mag,
	input  logic         neg,
	output mi3_pkg::fx_t recip
);
	localparam int NUM_W = 2 * FRAC_BITS + 1;

	logic [NUM_W-1:0] num_q [NUM_W+1];
	logic [NUM_W-1:0] quo_q [NUM_W+1];
	logic [32:0]      rem_q [NUM_W+1];
	logic [31:0]      div_q [NUM_W+1];
	logic             neg_q [NUM_W+1];

	always_comb begin
		num_q[0] = NUM_W'(1) << (2 * FRAC_BITS);
		quo_q[0] = '0;
		rem_q[0] = '0;
		div_q[0] = mag;
		neg_q[0] = neg;
	end

	// restoring division, one bit per stage
	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [33:0] trial;
		logic [32:0] shifted;
		always_comb begin
			shifted = {rem_q[i][31:0], num_q[i][NUM_W-1-i]};
			trial = {1'b0, shifted} - {2'b00, div_q[i]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				num_q[i+1] <= num_q[i];
				div_q[i+1] <= div_q[i];
				neg_q[i+1] <= neg_q[i];
				if (!trial[33]) begin
					rem_q[i+1] <= trial[32:0];
					quo_q[i+1] <= quo_q[i] | (NUM_W'(1) << (NUM_W - 1 - i));
				end else begin
					rem_q[i+1] <= shifted;
					quo_q[i+1] <= quo_q[i];
				end
			end
		end
	end

	// signed saturation of the quotient, compared at 64 bits
	logic [63:0] q;
	assign q = 64'(quo_q[NUM_W]);
	always_ff @(posedge clk) begin
		if (en) begin
			if (!neg_q[NUM_W]) begin
				recip <= (q > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
			end else begin
				recip <= (q > 64'h0000_0000_8000_0000) ? 32'sh8000_0000 : -q[31:0];
			end
		end
	end
endmodule

// ===== hdl/mi3_checker.sv =====
// Port-level checker for the matrix inverse core, bound to the top level.
module mi3_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic singular,
	input logic signed [31:0] inv_r0c1,
	input logic signed [31:0] inv_r1c0
);
	// a stalled result stays valid with its singular flag unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(singular))
		else $error("result changed while stalled");

	// an offered input stays offered until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input withdrawn before acceptance");

	// input is taken whenever the output register is empty
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// a singular result carries zero in the r0c1 and r1c0 elements
	a_ident: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> inv_r0c1 == 0 && inv_r1c0 == 0)
		else $error("singular result not identity");
endmodule

bind matrix_inverse_3x3_core mi3_checker u_mi3_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .singular(singular),
	.inv_r0c1(inv_r0c1), .inv_r1c0(inv_r1c0)
);

// ===== test/matrix_inverse_3x3_core_tb.sv =====
// Testbench for the 3x3 matrix inverse core: directed and random matrices, scored per result.
`timescale 1ns / 100ps

module matrix_inverse_3x3_core_tb;

	localparam int FRAC = 16;
	localparam int PIPE_LAT = 2 * FRAC + 16;
	localparam longint FX_MAX = 64'sd2147483647;
	localparam longint FX_MIN = -64'sd2147483648;
	localparam logic [31:0] ONE = 32'h0001_0000;

	typedef logic [8:0][31:0] mat_vec_t;
	typedef struct packed {
		mat_vec_t inv;
		logic sing;
	} inverse_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [30:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	mat_vec_t elem = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	mat_vec_t inv;
	logic singular;

	logic [30:0] tol_shadow = mi3_pkg::TOL_RESET;
	inverse_t pending_inverses[$];
	int err_count = 0;
	int hold_left = 0;
	bit steady = 1'b0;

	matrix_inverse_3x3_core #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.elem_r0c0(elem[0]), .elem_r0c1(elem[1]), .elem_r0c2(elem[2]),
		.elem_r1c0(elem[3]), .elem_r1c1(elem[4]), .elem_r1c2(elem[5]),
		.elem_r2c0(elem[6]), .elem_r2c1(elem[7]), .elem_r2c2(elem[8]),
		.out_valid(out_valid), .out_ready(out_ready),
		.inv_r0c0(inv[0]), .inv_r0c1(inv[1]), .inv_r0c2(inv[2]),
		.inv_r1c0(inv[3]), .inv_r1c1(inv[4]), .inv_r1c2(inv[5]),
		.inv_r2c0(inv[6]), .inv_r2c1(inv[7]), .inv_r2c2(inv[8]),
		.singular(singular)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Fixed-point arithmetic, saturating
	function automatic longint clamp32(longint v);
		if (v > FX_MAX) return FX_MAX;
		if (v < FX_MIN) return FX_MIN;
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		longint p;
		p = a * b + (64'sd1 <<< (FRAC - 1));
		return clamp32(p >>> FRAC);
	endfunction

	function automatic longint cofactor(longint a, longint b, longint c, longint d);
		return clamp32(qmul(a, b) - qmul(c, d));
	endfunction

	// Adjugate inverse of one matrix under the current tolerance
	function automatic inverse_t invert(mat_vec_t m);
		inverse_t r;
		longint a[9];
		longint c[9];
		longint det, mag, recip;
		longint unsigned q;
		for (int i = 0; i < 9; i++) a[i] = longint'($signed(m[i]));
		c[0] = cofactor(a[4], a[8], a[5], a[7]);
		c[1] = cofactor(a[2], a[7], a[1], a[8]);
		c[2] = cofactor(a[1], a[5], a[2], a[4]);
		c[3] = cofactor(a[5], a[6], a[3], a[8]);
		c[4] = cofactor(a[0], a[8], a[2], a[6]);
		c[5] = cofactor(a[2], a[3], a[0], a[5]);
		c[6] = cofactor(a[3], a[7], a[4], a[6]);
		c[7] = cofactor(a[1], a[6], a[0], a[7]);
		c[8] = cofactor(a[0], a[4], a[1], a[3]);
		det = clamp32(clamp32(qmul(a[0], c[0])
			- qmul(a[1], cofactor(a[3], a[8], a[5], a[6])))
			+ qmul(a[2], cofactor(a[3], a[7], a[4], a[6])));
		mag = (det < 0) ? -det : det;
		if (mag <= longint'(tol_shadow) || mag == 0) begin
			for (int i = 0; i < 9; i++) r.inv[i] = (i % 4 == 0) ? ONE : 32'h0;
			r.sing = 1'b1;
			return r;
		end
		q = (64'd1 << (2 * FRAC)) / longint'(mag);
		if (det > 0) recip = (q > 64'd2147483647) ? FX_MAX : longint'(q);
		else recip = (q > 64'd2147483648) ? FX_MIN : -longint'(q);
		for (int i = 0; i < 9; i++) r.inv[i] = 32'(qmul(recip, c[i]));
		r.sing = 1'b0;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch %s got %h want %h", $time, what, got, want);
		err_count++;
	endtask

	function automatic int idle_len();
		int p;
		if (steady) return 0;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Sender: one matrix per transaction
	task automatic send_matrix(mat_vec_t m);
		int g;
		@(negedge clk);
		elem = m;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_inverses.push_back(invert(m));
		g = idle_len();
		if (g > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		stop_sending();
		wait (pending_inverses.size() == 0);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [30:0] t);
		drain();
		@(negedge clk);
		cfg_data = t;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		tol_shadow = t;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Receiver: random stalls, long holds at random or when requested, always ready when steady
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else if (steady) begin
				out_ready = 1'b1;
			end else begin
				out_ready = ($urandom_range(0, 99) < 70) || ($urandom_range(0, 49) == 0)
					? 1'b1 : 1'b0;
				if ($urandom_range(0, 199) == 0) hold_left = $urandom_range(10, 40);
			end
		end
	end

	// Scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_inverses.size() == 0) begin
				report("unexpected result", inv[0], 32'h0);
			end else begin
				inverse_t w;
				w = pending_inverses.pop_front();
				for (int i = 0; i < 9; i++)
					if (inv[i] !== w.inv[i]) report($sformatf("inv[%0d]", i), inv[i], w.inv[i]);
				if (singular !== w.sing)
					report("singular", {31'b0, singular}, {31'b0, w.sing});
			end
		end
	end

	function automatic mat_vec_t diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		mat_vec_t m;
		m = '0;
		m[0] = a;
		m[4] = b;
		m[8] = c;
		return m;
	endfunction

	function automatic logic [31:0] small_fx();
		return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
	endfunction

	function automatic mat_vec_t random_matrix();
		mat_vec_t m;
		int p;
		p = $urandom_range(0, 99);
		for (int i = 0; i < 9; i++) m[i] = (p < 20) ? $urandom() : small_fx();
		if (p >= 20 && p < 30) m[6 +: 3] = m[0 +: 3];        // repeated row
		else if (p >= 30 && p < 35) m[$urandom_range(0, 8)] = $urandom();
		else if (p >= 35 && p < 40) for (int i = 0; i < 9; i++) m[i] = m[i] >>> 6;
		return m;
	endfunction

	task automatic test_directed();
		mat_vec_t m;
		send_matrix(diag(ONE, ONE, ONE));
		send_matrix('0);
		send_matrix({9{32'h7FFF_FFFF}});
		send_matrix({9{32'h8000_0000}});
		send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_matrix(diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		send_matrix(diag(32'hFFFE_0000, ONE, 32'h4000_0000));  // determinant at most negative
		send_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
		send_matrix(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0100));
		send_matrix(diag(32'h0000_8000, 32'h0000_8000, 32'h0002_0000));  // determinant of one half
		send_matrix(diag(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_matrix(diag(32'h0000_0004, ONE, 32'h0000_4000));   // tiny determinant
		m = '0;
		m[2] = ONE; m[4] = 32'hFFFF_0000; m[6] = 32'h0002_0000;
		send_matrix(m);                                           // permutation with a negative entry
		m = {32'h0001_8000, 32'h0000_4000, 32'hFFFF_C000, 32'h0000_0000, 32'h0002_0000,
			32'h0000_8000, 32'hFFFF_8000, 32'h0000_2000, 32'h0001_0000};
		send_matrix(m);
		m[6 +: 3] = m[3 +: 3];
		send_matrix(m);                                           // singular by repeated row
		for (int i = 0; i < 4; i++) send_matrix({$urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
	endtask

	task automatic test_tolerance_extremes();
		write_tolerance(31'd0);
		send_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
		send_matrix(diag(32'h0000_0100, ONE, ONE));
		send_matrix(diag(32'hFFFE_0000, ONE, 32'h4000_0000));
		write_tolerance(31'h7FFF_FFFF);
		send_matrix(diag(ONE, ONE, ONE));
		send_matrix(diag(32'hFFFE_0000, ONE, 32'h4000_0000));
		send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		write_tolerance(31'h0000_1000);
		for (int i = 0; i < 20; i++) send_matrix(random_matrix());
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 200 == 0) steady = ($urandom_range(0, 3) == 0);
			send_matrix(random_matrix());
		end
		steady = 1'b0;
	endtask

	task automatic test_backpressure();
		drain();
		@(posedge clk);
		hold_left = 400;
		for (int i = 0; i < 120; i++) send_matrix(random_matrix());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_tolerance_extremes();
		write_tolerance(31'd1);
		test_random(450);
		test_backpressure();
		write_tolerance(31'($urandom()) & 31'h0000_FFFF);
		test_random(400);
		write_tolerance(31'($urandom()));
		test_random(380);
		drain();
		if (err_count == 0) $display("matrix_inverse_3x3_core_tb: done, clean");
		else $display("matrix_inverse_3x3_core_tb: done, errors");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("matrix_inverse_3x3_core_tb: done, errors");
		$finish;
	end

endmodule
